/* design/tbt_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit: shared definitions
// Field widths of the stream words and the lane count of the divider bank.
// ----------------------------------------------------------------------------
package tbt_pkg;

  localparam int unsigned IdxW      = 16;
  localparam int unsigned PosW      = 48;
  localparam int unsigned TexW      = 32;
  localparam int unsigned VecW      = 60;
  localparam int unsigned NumLanes  = 6;
  localparam int unsigned InDataW   = 3 * IdxW + 3 * PosW + 3 * TexW;
  localparam int unsigned OutDataW  = 3 * IdxW + 2 * VecW;

endpackage

/* design/triangle_tangent_bitangent_core.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit: top level
// Computes the tangent and bitangent of one triangle per word.
// ----------------------------------------------------------------------------
// The slave channel takes one triangle per word: three vertex indices, three
// packed positions and three packed texture coordinates. The master channel
// returns the three indices, the packed tangent and bitangent, and a
// degenerate flag in tuser; on a zero UV determinant both vectors are zero.
// The pipeline has four front stages (deltas, products, determinant,
// magnitudes), one range check stage, one stage per quotient bit
// (ResultBits + 2) and one rounding stage. Throughput is one word per
// cycle; the six divider lanes are fully pipelined. When the receiver
// stalls with a word waiting at the output, the whole pipeline holds and
// s_axis_tready drops; words in flight are kept, never dropped or repeated.
// Reset clears the valid bits only; no data path register is cleared.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_core #(
  parameter int unsigned CoordBits  = 16,
  parameter int unsigned ResultBits = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // idx_a, idx_b, idx_c, pos_a, pos_b, pos_c, tex_a, tex_b, tex_c
  input  logic [tbt_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // idx_a, idx_b, idx_c, tangent, bitangent
  output logic [tbt_pkg::OutDataW-1:0]    m_axis_tdata,
  // degenerate
  output logic                            m_axis_tuser
);

  localparam int unsigned IW   = tbt_pkg::IdxW;
  localparam int unsigned PWd  = tbt_pkg::PosW;
  localparam int unsigned TW   = tbt_pkg::TexW;
  localparam int unsigned MW   = 2 * CoordBits + 3;
  localparam int unsigned DLat = ResultBits + 4;
  localparam int unsigned Lat  = 4 + DLat;

  logic           en;
  logic [Lat-1:0] v_q, v_d;

  assign en            = ~v_q[Lat-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[Lat-1];
  assign v_d           = {v_q[Lat-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  logic [IW-1:0]                 f_ia, f_ib, f_ic;
  logic                          f_zero;
  logic [MW-1:0]                 f_den;
  logic [MW-1:0]                 f_num [tbt_pkg::NumLanes];
  logic [tbt_pkg::NumLanes-1:0]  f_neg;

  tbt_front #(.CoordBits(CoordBits)) u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .idx_a_i    (s_axis_tdata[0 +: IW]),
    .idx_b_i    (s_axis_tdata[IW +: IW]),
    .idx_c_i    (s_axis_tdata[2*IW +: IW]),
    .pos_a_i    (s_axis_tdata[3*IW +: PWd]),
    .pos_b_i    (s_axis_tdata[3*IW+PWd +: PWd]),
    .pos_c_i    (s_axis_tdata[3*IW+2*PWd +: PWd]),
    .tex_a_i    (s_axis_tdata[3*IW+3*PWd +: TW]),
    .tex_b_i    (s_axis_tdata[3*IW+3*PWd+TW +: TW]),
    .tex_c_i    (s_axis_tdata[3*IW+3*PWd+2*TW +: TW]),
    .idx_a_o    (f_ia),
    .idx_b_o    (f_ib),
    .idx_c_o    (f_ic),
    .det_zero_o (f_zero),
    .den_mag_o  (f_den),
    .num_mag_o  (f_num),
    .neg_o      (f_neg)
  );

  logic signed [ResultBits-1:0] res [tbt_pkg::NumLanes];

  for (genvar l = 0; l < tbt_pkg::NumLanes; l++) begin : g_lane
    tbt_div #(.CoordBits(CoordBits), .ResultBits(ResultBits)) u_div (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_mag_i (f_num[l]),
      .den_mag_i (f_den),
      .neg_i     (f_neg[l]),
      .res_o     (res[l])
    );
  end

  // Indices and the degenerate flag wait alongside the divider lanes.
  logic [IW-1:0] ia_q [DLat];
  logic [IW-1:0] ib_q [DLat];
  logic [IW-1:0] ic_q [DLat];
  logic          zero_q [DLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ia_q[0]   <= f_ia;
      ib_q[0]   <= f_ib;
      ic_q[0]   <= f_ic;
      zero_q[0] <= f_zero;
      for (int s = 1; s < DLat; s++) begin
        ia_q[s]   <= ia_q[s-1];
        ib_q[s]   <= ib_q[s-1];
        ic_q[s]   <= ic_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  logic [3*ResultBits-1:0] tan_w, bit_w;
  logic [tbt_pkg::VecW-1:0] tan_v, bit_v;
  logic                     degen;

  assign tan_w = {res[2], res[1], res[0]};
  assign bit_w = {res[5], res[4], res[3]};
  assign degen = zero_q[DLat-1];
  assign tan_v = degen ? '0 : tbt_pkg::VecW'(tan_w);
  assign bit_v = degen ? '0 : tbt_pkg::VecW'(bit_w);

  assign m_axis_tdata = {bit_v, tan_v, ic_q[DLat-1], ib_q[DLat-1], ia_q[DLat-1]};
  assign m_axis_tuser = degen;

endmodule

/* design/tbt_front.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit: front end
// Four stages: edge and UV deltas, products, determinant and numerators,
// then magnitudes and quotient signs for the divider lanes.
// ----------------------------------------------------------------------------
module tbt_front #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tbt_pkg::IdxW-1:0]    idx_a_i,
  input  logic [tbt_pkg::IdxW-1:0]    idx_b_i,
  input  logic [tbt_pkg::IdxW-1:0]    idx_c_i,
  input  logic [tbt_pkg::PosW-1:0]    pos_a_i,
  input  logic [tbt_pkg::PosW-1:0]    pos_b_i,
  input  logic [tbt_pkg::PosW-1:0]    pos_c_i,
  input  logic [tbt_pkg::TexW-1:0]    tex_a_i,
  input  logic [tbt_pkg::TexW-1:0]    tex_b_i,
  input  logic [tbt_pkg::TexW-1:0]    tex_c_i,
  output logic [tbt_pkg::IdxW-1:0]    idx_a_o,
  output logic [tbt_pkg::IdxW-1:0]    idx_b_o,
  output logic [tbt_pkg::IdxW-1:0]    idx_c_o,
  output logic                        det_zero_o,
  output logic [2*CoordBits+2:0]      den_mag_o,
  output logic [2*CoordBits+2:0]      num_mag_o [tbt_pkg::NumLanes],
  output logic [tbt_pkg::NumLanes-1:0] neg_o
);

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;

  logic [63:0] pa, pb, pc, ta, tb, tc;
  assign pa = 64'(pos_a_i);
  assign pb = 64'(pos_b_i);
  assign pc = 64'(pos_c_i);
  assign ta = 64'(tex_a_i);
  assign tb = 64'(tex_b_i);
  assign tc = 64'(tex_c_i);

  // Stage 1: differences around vertex b.
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic [tbt_pkg::IdxW-1:0] ia_q [4];
  logic [tbt_pkg::IdxW-1:0] ib_q [4];
  logic [tbt_pkg::IdxW-1:0] ic_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= DW'($signed(pa[k*CoordBits +: CoordBits]))
                 - DW'($signed(pb[k*CoordBits +: CoordBits]));
        e2_q[k] <= DW'($signed(pc[k*CoordBits +: CoordBits]))
                 - DW'($signed(pb[k*CoordBits +: CoordBits]));
      end
      d1u_q <= DW'($signed(ta[0 +: CoordBits])) - DW'($signed(tb[0 +: CoordBits]));
      d1v_q <= DW'($signed(ta[CoordBits +: CoordBits]))
             - DW'($signed(tb[CoordBits +: CoordBits]));
      d2u_q <= DW'($signed(tc[0 +: CoordBits])) - DW'($signed(tb[0 +: CoordBits]));
      d2v_q <= DW'($signed(tc[CoordBits +: CoordBits]))
             - DW'($signed(tb[CoordBits +: CoordBits]));
      ia_q[0] <= idx_a_i;
      ib_q[0] <= idx_b_i;
      ic_q[0] <= idx_c_i;
      for (int s = 1; s < 4; s++) begin
        ia_q[s] <= ia_q[s-1];
        ib_q[s] <= ib_q[s-1];
        ic_q[s] <= ic_q[s-1];
      end
    end
  end

  // Stage 2: products. Lanes 0..2 are tangent x,y,z, lanes 3..5 bitangent.
  logic signed [PW-1:0] pdet_a_q, pdet_b_q;
  logic signed [PW-1:0] pp_q [tbt_pkg::NumLanes];
  logic signed [PW-1:0] pm_q [tbt_pkg::NumLanes];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pdet_a_q <= PW'(d1u_q) * PW'(d2v_q);
      pdet_b_q <= PW'(d2u_q) * PW'(d1v_q);
      for (int k = 0; k < 3; k++) begin
        pp_q[k]   <= PW'(d2v_q) * PW'(e1_q[k]);
        pm_q[k]   <= PW'(d1v_q) * PW'(e2_q[k]);
        pp_q[k+3] <= PW'(d1u_q) * PW'(e2_q[k]);
        pm_q[k+3] <= PW'(d2u_q) * PW'(e1_q[k]);
      end
    end
  end

  // Stage 3: determinant and numerators.
  logic signed [NW-1:0] det_q;
  logic signed [NW-1:0] num_q [tbt_pkg::NumLanes];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= NW'(pdet_a_q) - NW'(pdet_b_q);
      for (int l = 0; l < tbt_pkg::NumLanes; l++) begin
        num_q[l] <= NW'(pp_q[l]) - NW'(pm_q[l]);
      end
    end
  end

  // Stage 4: magnitudes for the unsigned divider.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_zero_o <= (det_q == '0);
      den_mag_o  <= det_q[NW-1] ? NW'(-det_q) : NW'(det_q);
      for (int l = 0; l < tbt_pkg::NumLanes; l++) begin
        num_mag_o[l] <= num_q[l][NW-1] ? NW'(-num_q[l]) : NW'(num_q[l]);
        neg_o[l]     <= num_q[l][NW-1] ^ det_q[NW-1];
      end
    end
  end

  assign idx_a_o = ia_q[3];
  assign idx_b_o = ib_q[3];
  assign idx_c_o = ic_q[3];

endmodule

/* design/tbt_div.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit: divider lane
// Pipelined restoring divider, one quotient bit per stage, followed by
// rounding to nearest (ties away from zero) and saturation.
// ----------------------------------------------------------------------------
module tbt_div #(
  parameter int unsigned CoordBits  = 16,
  parameter int unsigned ResultBits = 20
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [2*CoordBits+2:0]       num_mag_i,
  input  logic [2*CoordBits+2:0]       den_mag_i,
  input  logic                         neg_i,
  output logic signed [ResultBits-1:0] res_o
);

  localparam int unsigned MW  = 2 * CoordBits + 3;
  localparam int unsigned QS  = CoordBits - 2 - CoordBits / 2 + ResultBits / 2;
  localparam int unsigned K   = ResultBits + 2;
  localparam int unsigned RW  = MW + K;
  localparam int unsigned XW  = MW + ((QS + 1 > K) ? QS + 1 : K);
  localparam logic [K-1:0] Cap    = K'(1) << (ResultBits + 1);
  localparam logic [K-1:0] ResMax = (K'(1) << (ResultBits - 1)) - K'(1);

  logic [RW-1:0] r_q   [K+1];
  logic [K-1:0]  q_q   [K+1];
  logic [MW-1:0] d_q   [K+1];
  logic          ovf_q [K+1];
  logic          neg_q [K+1];
  logic [RW:0]   trial [K];

  logic [XW-1:0] dividend, den_top;
  assign dividend = XW'(num_mag_i) << (QS + 1);
  assign den_top  = XW'(den_mag_i) << K;

  always_comb begin
    for (int j = 0; j < K; j++) begin
      trial[j] = {1'b0, r_q[j]} - {1'b0, RW'(d_q[j]) << (K - 1 - j)};
    end
  end

  // The quotient must fit K bits, otherwise the result saturates.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (dividend >= den_top);
      r_q[0]   <= dividend[RW-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= den_mag_i;
      neg_q[0] <= neg_i;
      for (int j = 0; j < K; j++) begin
        r_q[j+1]   <= trial[j][RW] ? r_q[j] : trial[j][RW-1:0];
        q_q[j+1]   <= {q_q[j][K-2:0], ~trial[j][RW]};
        d_q[j+1]   <= d_q[j];
        ovf_q[j+1] <= ovf_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  logic [K-1:0]            q_rnd;
  logic                    sat;
  logic [ResultBits-1:0]   res_d;
  assign q_rnd = (q_q[K] + K'(1)) >> 1;
  assign sat   = ovf_q[K] || (q_q[K] > Cap);

  always_comb begin
    if (neg_q[K]) begin
      if (sat || q_rnd > ResMax + K'(1)) begin
        res_d = {1'b1, {(ResultBits-1){1'b0}}};
      end else begin
        res_d = ResultBits'(-q_rnd);
      end
    end else begin
      if (sat || q_rnd > ResMax) begin
        res_d = {1'b0, {(ResultBits-1){1'b1}}};
      end else begin
        res_d = ResultBits'(q_rnd);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule
